@@ hw/rtl/pbwe_pkg.sv @@
// shared constants, request codes and payload types for the packed base window editor
package pbwe_pkg;

    // default geometry of the window
    localparam int BASES_PER_BLOCK_DEF = 10;
    localparam int NUM_BLOCKS_DEF      = 3;
    localparam int MAX_INSERT_DEF      = 32;

    // field widths on the channels
    localparam int TYPE_W  = 3;
    localparam int POS_W   = 5;
    localparam int BASE_W  = 2;
    localparam int CNT_W   = 6;
    localparam int INS_W   = 64;
    localparam int WORD_W  = 20;
    localparam int INDEX_W = 2;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_CHANGE    = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_DEL_RIGHT = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_DEL_LEFT  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_INS_RIGHT = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_INS_LEFT  = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_LOAD      = 3'd5;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [POS_W-1:0]  pos;
        logic [BASE_W-1:0] base;
        logic [CNT_W-1:0]  ins_count;
        logic [INS_W-1:0]  ins_bases;
        logic [WORD_W-1:0] load_value;
    } req_t;

endpackage

@@ hw/rtl/pbwe_ifs.sv @@
// valid/ready channel interfaces for request words and block words
interface pbwe_req_if;
    import pbwe_pkg::*;

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [POS_W-1:0]  pos;
    logic [BASE_W-1:0] base;
    logic [CNT_W-1:0]  ins_count;
    logic [INS_W-1:0]  ins_bases;
    logic [WORD_W-1:0] load_value;

    modport source (
        output valid, req_type, pos, base, ins_count, ins_bases, load_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos, base, ins_count, ins_bases, load_value,
        output ready
    );
endinterface

interface pbwe_blk_if;
    import pbwe_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] block_index;
    logic [WORD_W-1:0]  block_word;
    logic               last_block;

    modport source (
        output valid, block_index, block_word, last_block,
        input  ready
    );
    modport sink (
        input  valid, block_index, block_word, last_block,
        output ready
    );
endinterface

@@ hw/rtl/pbwe_edit.sv @@
// combinational window edit: change, deletes, inserts and block load on the packed window
module pbwe_edit #(
    parameter int BASES_PER_BLOCK = pbwe_pkg::BASES_PER_BLOCK_DEF,
    parameter int NUM_BLOCKS      = pbwe_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_INSERT      = pbwe_pkg::MAX_INSERT_DEF
) (
    input  pbwe_pkg::req_t                              req,
    input  logic [2*BASES_PER_BLOCK*NUM_BLOCKS-1:0]     win_old,
    output logic [2*BASES_PER_BLOCK*NUM_BLOCKS-1:0]     win_new
);
    import pbwe_pkg::*;

    localparam int L  = BASES_PER_BLOCK * NUM_BLOCKS;
    localparam int BW = 2 * BASES_PER_BLOCK;
    localparam int PW = (L > 1) ? $clog2(L) : 1;
    localparam int IW = (MAX_INSERT > 1) ? $clog2(MAX_INSERT) : 1;

    logic [1:0]   old_b [L];
    logic [1:0]   ins_b [MAX_INSERT];
    logic [1:0]   new_b [L];
    logic [L*2-1:0] win_edit;

    always_comb
    begin
        int pos_i;
        int cnt;
        int n_rt;
        int n_lt;
        int src;

        pos_i = int'(req.pos);
        cnt   = int'(req.ins_count);
        if (cnt > MAX_INSERT)
        begin
            cnt = MAX_INSERT;
        end
        // room left on each side of the position
        n_rt = (cnt > L - pos_i) ? L - pos_i : cnt;
        n_lt = (cnt > pos_i + 1) ? pos_i + 1 : cnt;

        for (int i = 0; i < MAX_INSERT; i++)
        begin
            ins_b[i] = req.ins_bases[2*i +: 2];
        end

        for (int p = 0; p < L; p++)
        begin
            old_b[p] = win_old[2*(L-1-p) +: 2];
        end

        for (int p = 0; p < L; p++)
        begin
            new_b[p] = old_b[p];
            src      = 0;
            case (req.req_type)
                REQ_CHANGE:
                begin
                    if (p == pos_i)
                    begin
                        new_b[p] = req.base;
                    end
                end
                REQ_DEL_RIGHT:
                begin
                    if (p == L - 1)
                    begin
                        new_b[p] = req.base;
                    end
                    else if (p >= pos_i)
                    begin
                        src      = p + 1;
                        new_b[p] = old_b[src[PW-1:0]];
                    end
                end
                REQ_DEL_LEFT:
                begin
                    if (p == 0)
                    begin
                        new_b[p] = req.base;
                    end
                    else if (p <= pos_i)
                    begin
                        src      = p - 1;
                        new_b[p] = old_b[src[PW-1:0]];
                    end
                end
                REQ_INS_RIGHT:
                begin
                    if (p >= pos_i && p < pos_i + n_rt)
                    begin
                        src      = p - pos_i;
                        new_b[p] = ins_b[src[IW-1:0]];
                    end
                    else if (p >= pos_i)
                    begin
                        src      = p - n_rt;
                        new_b[p] = old_b[src[PW-1:0]];
                    end
                end
                REQ_INS_LEFT:
                begin
                    if (p + n_lt <= pos_i)
                    begin
                        src      = p + n_lt;
                        new_b[p] = old_b[src[PW-1:0]];
                    end
                    else if (p <= pos_i)
                    begin
                        // tail of the string ends at the position
                        src      = cnt + p - pos_i - 1;
                        new_b[p] = ins_b[src[IW-1:0]];
                    end
                end
                default:
                begin
                    new_b[p] = old_b[p];
                end
            endcase
        end

        for (int p = 0; p < L; p++)
        begin
            win_edit[2*(L-1-p) +: 2] = new_b[p];
        end

        win_new = win_old;
        if (req.req_type <= REQ_INS_LEFT && pos_i < L)
        begin
            win_new = win_edit;
        end
        else if (req.req_type == REQ_LOAD)
        begin
            for (int k = 0; k < NUM_BLOCKS; k++)
            begin
                if (pos_i == k)
                begin
                    win_new[BW*(NUM_BLOCKS-1-k) +: BW] = BW'(req.load_value);
                end
            end
        end
    end

endmodule

@@ hw/rtl/packed_base_window_editor_top.sv @@
// top level of the packed base window editor: request register, window edit, block word emitter
//
// The block keeps a window of NUM_BLOCKS * BASES_PER_BLOCK two-bit bases, position 0 in the
// most significant pair of block 0. Each request word (change, delete from either side, insert
// from either side, or load of a whole block) is captured in an input register, applied to the
// window in one pass of combinational shift logic, and the edited window is copied into a
// snapshot. The snapshot is then sent out as NUM_BLOCKS block words, index 0 first, with
// last_block set on the final one; each block word goes out through the output register. The
// input register takes the next request while the previous snapshot is still going out, and a
// new edit lands in the same cycle the last word of the previous run leaves the snapshot. The
// first block word is offered after the request has gone through the input register and the
// snapshot. Requests with an out-of-range position or an unknown type leave the window untouched
// and still produce a full run of block words. After reset the window is all zero.
module packed_base_window_editor_top #(
    parameter int BASES_PER_BLOCK = pbwe_pkg::BASES_PER_BLOCK_DEF,
    parameter int NUM_BLOCKS      = pbwe_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_INSERT      = pbwe_pkg::MAX_INSERT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pbwe_req_if.sink   req,
    pbwe_blk_if.source blk
);
    import pbwe_pkg::*;

    localparam int BW = 2 * BASES_PER_BLOCK;
    localparam int WW = BW * NUM_BLOCKS;
    localparam int XW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // input register
    logic          req_valid_reg;
    logic          req_valid_next;
    req_t          req_reg;
    req_t          req_in;

    // window state and the copy being emitted
    logic [WW-1:0] win_reg;
    logic [WW-1:0] win_edit;
    logic [WW-1:0] snap_reg;
    logic          snap_valid_reg;
    logic          snap_valid_next;
    logic [XW-1:0] snap_idx_reg;
    logic [XW-1:0] snap_idx_next;
    logic [BW-1:0] snap_blk [NUM_BLOCKS];

    // output register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [XW-1:0] out_idx_reg;
    logic [BW-1:0] out_word_reg;
    logic          out_last_reg;

    logic          snap_last;
    logic          snap_take;
    logic          edit_fire;
    logic          req_take;

    assign req_in.req_type   = req.req_type;
    assign req_in.pos        = req.pos;
    assign req_in.base       = req.base;
    assign req_in.ins_count  = req.ins_count;
    assign req_in.ins_bases  = req.ins_bases;
    assign req_in.load_value = req.load_value;

    // block view of the snapshot, block 0 in the top bits
    for (genvar k = 0; k < NUM_BLOCKS; k++)
    begin : g_snap_blk
        assign snap_blk[k] = snap_reg[BW*(NUM_BLOCKS-1-k) +: BW];
    end

    pbwe_edit #(
        .BASES_PER_BLOCK (BASES_PER_BLOCK),
        .NUM_BLOCKS      (NUM_BLOCKS),
        .MAX_INSERT      (MAX_INSERT)
    ) u_edit (
        .req     (req_reg),
        .win_old (win_reg),
        .win_new (win_edit)
    );

    // handshake: a word moves into the output register whenever it is free or being drained,
    // and the snapshot frees up when its last block moves out
    assign snap_last = (snap_idx_reg == XW'(NUM_BLOCKS - 1));
    assign snap_take = snap_valid_reg && (!out_valid_reg || blk.ready);
    assign edit_fire = req_valid_reg && (!snap_valid_reg || (snap_take && snap_last));
    assign req.ready = !req_valid_reg || edit_fire;
    assign req_take  = req.valid && req.ready;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req.ready)
        begin
            req_valid_next = req.valid;
        end

        snap_valid_next = snap_valid_reg;
        snap_idx_next   = snap_idx_reg;
        if (snap_take)
        begin
            if (snap_last)
            begin
                snap_valid_next = 1'b0;
            end
            else
            begin
                snap_idx_next = snap_idx_reg + 1'b1;
            end
        end
        if (edit_fire)
        begin
            snap_valid_next = 1'b1;
            snap_idx_next   = '0;
        end

        out_valid_next = out_valid_reg;
        if (snap_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (blk.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            snap_valid_reg <= 1'b0;
            snap_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            win_reg        <= '0;
        end
        else
        begin
            req_valid_reg  <= req_valid_next;
            snap_valid_reg <= snap_valid_next;
            snap_idx_reg   <= snap_idx_next;
            out_valid_reg  <= out_valid_next;
            if (edit_fire)
            begin
                win_reg <= win_edit;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req_in;
        end
        if (edit_fire)
        begin
            snap_reg <= win_edit;
        end
        if (snap_take)
        begin
            out_idx_reg  <= snap_idx_reg;
            out_word_reg <= snap_blk[snap_idx_reg];
            out_last_reg <= snap_last;
        end
    end

    assign blk.valid       = out_valid_reg;
    assign blk.block_index = INDEX_W'(out_idx_reg);
    assign blk.block_word  = WORD_W'(out_word_reg);
    assign blk.last_block  = out_last_reg;

endmodule

@@ hw/rtl/pbwe_checker.sv @@
// port-level checks on the block word stream of the window editor, bound to the top level
module pbwe_checker #(
    parameter int NUM_BLOCKS = pbwe_pkg::NUM_BLOCKS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         blk_valid,
    input logic                         blk_ready,
    input logic [pbwe_pkg::INDEX_W-1:0] blk_index,
    input logic [pbwe_pkg::WORD_W-1:0]  blk_word,
    input logic                         blk_last
);
    import pbwe_pkg::*;

    // a stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && !blk_ready |=> blk_valid && $stable(blk_index) && $stable(blk_word)
            && $stable(blk_last))
        else $error("block word changed while stalled");

    // a run continues without a gap, indices counting up
    a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && blk_ready && !blk_last |=> blk_valid
            && blk_index == INDEX_W'($past(blk_index) + 1'b1))
        else $error("block run broke or skipped an index");

    // the last flag marks exactly the final block index
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid |-> (blk_last == (blk_index == INDEX_W'(NUM_BLOCKS - 1))))
        else $error("last flag does not match block index");

    // a run after a last word starts at block zero
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && blk_ready && blk_last ##1 blk_valid |-> blk_index == '0)
        else $error("run did not start at block zero");

endmodule

bind packed_base_window_editor_top pbwe_checker #(
    .NUM_BLOCKS (NUM_BLOCKS)
) u_pbwe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_valid (blk.valid),
    .blk_ready (blk.ready),
    .blk_index (blk.block_index),
    .blk_word  (blk.block_word),
    .blk_last  (blk.last_block)
);

@@ test/testbench.sv @@
// self-checking testbench for the packed base window editor: driver, predictor and block word checker
`timescale 1ns / 1ps

module testbench;
    import pbwe_pkg::*;

    // window geometry at the default parameters of the block
    localparam int BPB       = BASES_PER_BLOCK_DEF;
    localparam int WIN_BASES = BASES_PER_BLOCK_DEF * NUM_BLOCKS_DEF;

    // request codes the block does not know; they must leave the window alone
    localparam logic [TYPE_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_SPARE_7 = 3'd7;

    localparam int RANDOM_REQS = 350;
    localparam int IDLE_LIMIT  = 2000;   // cycles with no word moving on either side
    localparam int LONG_HOLD   = 400;    // one long receiver hold-off to back the block up
    localparam int SETTLE      = 20;     // quiet cycles after the last block word

    typedef struct {
        logic [INDEX_W-1:0] blk_idx;
        logic [WORD_W-1:0]  bases;
        logic               is_last;
    } block_word_t;

    typedef struct {
        req_t word;
        bit   drain_first;   // hold this word back until every block word is in
    } queued_req_t;

    logic clk;
    logic rst_n;

    pbwe_req_if req_ch ();
    pbwe_blk_if blk_ch ();

    packed_base_window_editor_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .blk   (blk_ch)
    );

    // predictor state: one two-bit base per window position, position 0 first
    logic [1:0]  window_bases [WIN_BASES];

    queued_req_t pending_reqs [$];
    block_word_t block_words_due [$];

    req_t offered;
    int   send_gap;
    int   hold_left;
    bit   long_hold_done;
    int   reqs_total;
    int   reqs_accepted;
    int   words_checked;
    int   fail_count;
    int   idle_cycles;
    bit   took;

    // clock: 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: apply one accepted request word to the window and queue
    // the NUM_BLOCKS block words it must produce
    // ------------------------------------------------------------------
    task automatic predict_blocks(input req_t r);
        logic [1:0]        prior [WIN_BASES];
        int                cnt;
        int                n;
        int                p;
        logic [WORD_W-1:0] packed_word;
        block_word_t       due;
        prior = window_bases;
        cnt = (r.ins_count > MAX_INSERT_DEF) ? MAX_INSERT_DEF : int'(r.ins_count);
        p = int'(r.pos);
        if (r.req_type == REQ_LOAD)
        begin
            // pos names a block here; out-of-range blocks are ignored
            if (p < NUM_BLOCKS_DEF)
            begin
                for (int i = 0; i < BPB; i++)
                    window_bases[p * BPB + i] = r.load_value[2 * (BPB - 1 - i) +: 2];
            end
        end
        else if (r.req_type <= REQ_INS_LEFT && p < WIN_BASES)
        begin
            case (r.req_type)
                REQ_CHANGE:
                    window_bases[p] = r.base;
                REQ_DEL_RIGHT:
                begin
                    // tail slides toward position 0, new base enters at the far end
                    for (int i = p; i < WIN_BASES - 1; i++)
                        window_bases[i] = prior[i + 1];
                    window_bases[WIN_BASES - 1] = r.base;
                end
                REQ_DEL_LEFT:
                begin
                    // head slides toward the end, new base enters at position 0
                    for (int i = p; i > 0; i--)
                        window_bases[i] = prior[i - 1];
                    window_bases[0] = r.base;
                end
                REQ_INS_RIGHT:
                begin
                    // string starts at pos, cut to the room up to the end
                    n = (cnt < WIN_BASES - p) ? cnt : WIN_BASES - p;
                    for (int i = 0; i < n; i++)
                        window_bases[p + i] = r.ins_bases[2 * i +: 2];
                    for (int i = p + n; i < WIN_BASES; i++)
                        window_bases[i] = prior[i - n];
                end
                REQ_INS_LEFT:
                begin
                    // last n string bases end at pos, older bases pushed off the front
                    n = (cnt < p + 1) ? cnt : p + 1;
                    for (int i = 0; i + n <= p; i++)
                        window_bases[i] = prior[i + n];
                    for (int i = 0; i < n; i++)
                        window_bases[p + 1 - n + i] = r.ins_bases[2 * (cnt - n + i) +: 2];
                end
                default:
                    ;
            endcase
        end
        // every request, ignored or not, yields a full run of block words
        for (int b = 0; b < NUM_BLOCKS_DEF; b++)
        begin
            for (int i = 0; i < BPB; i++)
                packed_word[2 * (BPB - 1 - i) +: 2] = window_bases[b * BPB + i];
            due.blk_idx = INDEX_W'(b);
            due.bases   = packed_word;
            due.is_last = (b == NUM_BLOCKS_DEF - 1);
            block_words_due.push_back(due);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic req_t make_req(input logic [TYPE_W-1:0] kind, input int p, input int b,
                                      input int cnt, input logic [INS_W-1:0] ins,
                                      input logic [WORD_W-1:0] load);
        req_t r;
        r.req_type   = kind;
        r.pos        = POS_W'(p);
        r.base       = BASE_W'(b);
        r.ins_count  = CNT_W'(cnt);
        r.ins_bases  = ins;
        r.load_value = load;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 17)
            r.req_type = REQ_CHANGE;
        else if (pick < 33)
            r.req_type = REQ_DEL_RIGHT;
        else if (pick < 49)
            r.req_type = REQ_DEL_LEFT;
        else if (pick < 69)
            r.req_type = REQ_INS_RIGHT;
        else if (pick < 89)
            r.req_type = REQ_INS_LEFT;
        else if (pick < 97)
            r.req_type = REQ_LOAD;
        else
            r.req_type = $urandom_range(0, 1) ? REQ_SPARE_7 : REQ_SPARE_6;
        // mostly in-range positions, now and then past the end
        if (r.req_type == REQ_LOAD)
            r.pos = ($urandom_range(0, 99) < 85) ? POS_W'($urandom_range(0, NUM_BLOCKS_DEF - 1))
                                                 : POS_W'($urandom_range(NUM_BLOCKS_DEF, 31));
        else
            r.pos = ($urandom_range(0, 99) < 92) ? POS_W'($urandom_range(0, WIN_BASES - 1))
                                                 : POS_W'($urandom_range(WIN_BASES, 31));
        r.base = BASE_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 6)
            r.ins_count = '0;
        else if (pick < 14)
            r.ins_count = CNT_W'($urandom_range(MAX_INSERT_DEF + 1, 63));
        else
            r.ins_count = CNT_W'($urandom_range(1, MAX_INSERT_DEF));
        r.ins_bases  = {$urandom, $urandom};
        r.load_value = WORD_W'($urandom);
        return r;
    endfunction

    task automatic queue_req(input req_t r, input bit drain);
        queued_req_t q;
        q.word        = r;
        q.drain_first = drain;
        pending_reqs.push_back(q);
    endtask

    // idle length: mostly none or short, a few long; none at all in calm stretches
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued request words, predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            took = req_ch.valid && req_ch.ready;
            if (took)
            begin
                predict_blocks(offered);
                reqs_accepted++;
                // every third stretch of 40 words goes without sender gaps
                send_gap = pick_gap((reqs_accepted / 40) % 3 == 1);
            end
            // the slot is free when nothing is offered or the offer was just taken
            if (took || !req_ch.valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    req_ch.valid <= 1'b0;
                else if (pending_reqs[0].drain_first && block_words_due.size() != 0)
                    req_ch.valid <= 1'b0;   // pause until the block has emptied out
                else
                begin
                    offered = pending_reqs[0].word;
                    pending_reqs.delete(0);
                    req_ch.req_type   <= offered.req_type;
                    req_ch.pos        <= offered.pos;
                    req_ch.base       <= offered.base;
                    req_ch.ins_count  <= offered.ins_count;
                    req_ch.ins_bases  <= offered.ins_bases;
                    req_ch.load_value <= offered.load_value;
                    req_ch.valid      <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each accepted block word and drives ready with
    // random stalls plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_ch.ready <= 1'b0;
            hold_left = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (blk_ch.valid && blk_ch.ready)
            begin
                if (block_words_due.size() == 0)
                begin
                    $display("%0t: unexpected block word idx %0d word %h last %0b", $time,
                             blk_ch.block_index, blk_ch.block_word, blk_ch.last_block);
                    fail_count++;
                end
                else
                begin
                    automatic block_word_t due = block_words_due.pop_front();
                    if (blk_ch.block_index !== due.blk_idx)
                    begin
                        $display("%0t: block_index expected %0d actual %0d", $time,
                                 due.blk_idx, blk_ch.block_index);
                        fail_count++;
                    end
                    if (blk_ch.block_word !== due.bases)
                    begin
                        $display("%0t: block_word (block %0d) expected %h actual %h", $time,
                                 due.blk_idx, due.bases, blk_ch.block_word);
                        fail_count++;
                    end
                    if (blk_ch.last_block !== due.is_last)
                    begin
                        $display("%0t: last_block (block %0d) expected %0b actual %0b", $time,
                                 due.blk_idx, due.is_last, blk_ch.last_block);
                        fail_count++;
                    end
                end
                words_checked++;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                blk_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && words_checked >= 150)
            begin
                // long hold-off: the sender keeps offering, so the block backs up
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                blk_ch.ready <= 1'b0;
            end
            else if ((words_checked / 120) % 3 != 2 && $urandom_range(0, 99) < 20)
            begin
                // start a stall, mostly short
                hold_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                         : $urandom_range(7, 39);
                blk_ch.ready <= 1'b0;
            end
            else
                blk_ch.ready <= 1'b1;
        end
    end

    // watchdog: too long with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (blk_ch.valid && blk_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.pos = '0;
        req_ch.base = '0;
        req_ch.ins_count = '0;
        req_ch.ins_bases = '0;
        req_ch.load_value = '0;
        blk_ch.ready = 1'b0;
        for (int i = 0; i < WIN_BASES; i++)
            window_bases[i] = 2'd0;
        reqs_accepted = 0;
        words_checked = 0;
        fail_count = 0;
        idle_cycles = 0;

        // directed: loads, including out-of-range blocks
        queue_req(make_req(REQ_LOAD, 0, 0, 0, '0, 20'hFFFFF), 1'b0);
        queue_req(make_req(REQ_LOAD, 1, 0, 0, '0, 20'h00000), 1'b0);
        queue_req(make_req(REQ_LOAD, 2, 0, 0, '0, 20'h1B1E4), 1'b0);
        queue_req(make_req(REQ_LOAD, 3, 0, 0, '0, 20'h12345), 1'b0);
        queue_req(make_req(REQ_LOAD, 31, 0, 0, '0, 20'hABCDE), 1'b0);
        // change at both ends and past the end
        queue_req(make_req(REQ_CHANGE, 0, 1, 0, '0, '0), 1'b0);
        queue_req(make_req(REQ_CHANGE, WIN_BASES - 1, 2, 0, '0, '0), 1'b0);
        queue_req(make_req(REQ_CHANGE, WIN_BASES, 3, 0, '0, '0), 1'b0);
        queue_req(make_req(REQ_CHANGE, 31, 3, 0, '0, '0), 1'b0);
        // deletes from either side at both ends
        queue_req(make_req(REQ_DEL_RIGHT, 0, 1, 0, '0, '0), 1'b0);
        queue_req(make_req(REQ_DEL_RIGHT, WIN_BASES - 1, 3, 0, '0, '0), 1'b0);
        queue_req(make_req(REQ_DEL_LEFT, WIN_BASES - 1, 2, 0, '0, '0), 1'b0);
        queue_req(make_req(REQ_DEL_LEFT, 0, 3, 0, '0, '0), 1'b0);
        // inserts: full string, cut to the room left, empty, oversized count
        queue_req(make_req(REQ_INS_RIGHT, 0, 0, MAX_INSERT_DEF, 64'h0123_4567_89AB_CDEF, '0),
                  1'b0);
        queue_req(make_req(REQ_INS_RIGHT, 25, 0, 10, 64'hFFFF_FFFF_FFFF_FFFF, '0), 1'b0);
        queue_req(make_req(REQ_INS_RIGHT, 7, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, '0), 1'b0);
        queue_req(make_req(REQ_INS_RIGHT, 3, 0, 63, 64'hA5A5_5A5A_C3C3_3C3C, '0), 1'b0);
        queue_req(make_req(REQ_INS_LEFT, WIN_BASES - 1, 0, 33, 64'hFEDC_BA98_7654_3210, '0),
                  1'b0);
        queue_req(make_req(REQ_INS_LEFT, 3, 0, 10, 64'h0000_0000_000F_FFFF, '0), 1'b0);
        queue_req(make_req(REQ_INS_LEFT, 0, 0, 1, 64'h0000_0000_0000_0002, '0), 1'b0);
        queue_req(make_req(REQ_INS_LEFT, 12, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, '0), 1'b0);
        queue_req(make_req(REQ_INS_LEFT, WIN_BASES, 0, 5, 64'hFFFF_FFFF_FFFF_FFFF, '0), 1'b0);
        // unknown request codes
        queue_req(make_req(REQ_SPARE_6, 4, 3, 8, 64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF), 1'b0);
        queue_req(make_req(REQ_SPARE_7, 9, 1, 8, 64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF), 1'b0);

        // random part; a few words wait for the block to drain first
        for (int i = 0; i < RANDOM_REQS; i++)
            queue_req(random_request(), i == 0 || i == 120 || i == 260);
        reqs_total = pending_reqs.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (reqs_accepted != reqs_total)
            @(posedge clk);
        while (block_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0 && block_words_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/pbwe_pkg.sv
hw/rtl/pbwe_ifs.sv
hw/rtl/pbwe_edit.sv
hw/rtl/packed_base_window_editor_top.sv
hw/rtl/pbwe_checker.sv
test/testbench.sv
